[sv/fca_pkg.sv]
`default_nettype none

package fca_pkg;

	// field widths
	localparam int OP_W    = 3;
	localparam int BLOCK_W = 13;
	localparam int CNT_W   = 13;
	localparam int ENTRY_W = 14;

	// table geometry and reset values
	localparam int                 NUM_BLOCKS_DEF = 8192;
	localparam logic [ENTRY_W-1:0] FAT_FREE       = 14'h3FFF;
	localparam logic [BLOCK_W-1:0] DATA_START_RST = 13'd10;

	// register map
	localparam int               APB_ADDR_W      = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_DATA_START = 2'd0;

	// request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_APPEND   = 3'd1,
		OP_WALK     = 3'd2,
		OP_FREE     = 3'd3,
		OP_TRUNCATE = 3'd4
	} opcode_t;

	// evaluation of one table entry by the shared link unit
	typedef struct packed {
		logic entry_free;
		logic link_ends;
		logic skip_hit;
		logic at_last;
	} link_flags_t;

endpackage

`default_nettype wire

[sv/fca_ram.sv]
`default_nettype none

module fca_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/fca_link_unit.sv]
`default_nettype none

module fca_link_unit #(
	parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF,
	localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
	input  wire logic [IDX_W-1:0]            cur,
	input  wire logic [fca_pkg::ENTRY_W-1:0] entry,
	input  wire logic [IDX_W-1:0]            skip,
	output fca_pkg::link_flags_t             flags,
	output logic      [IDX_W-1:0]            next
);

	localparam logic [fca_pkg::ENTRY_W-1:0] NUM_L = fca_pkg::ENTRY_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0]            LAST  = IDX_W'(NUM_BLOCKS - 1);

	logic [fca_pkg::ENTRY_W-1:0] cur_ext;

	assign cur_ext = fca_pkg::ENTRY_W'(cur);

	// classify the entry read for the current block
	always_comb begin
		flags.entry_free = (entry == fca_pkg::FAT_FREE);
		flags.link_ends  = flags.entry_free || (entry >= NUM_L) || (entry == cur_ext);
		flags.skip_hit   = (cur == skip);
		flags.at_last    = (cur == LAST);
	end

	// shared address incrementer for scan and clear
	assign next = cur + IDX_W'(1);

endmodule

`default_nettype wire

[sv/fat_chain_allocator.sv]
`default_nettype none

// File allocation table of linked block chains, one request at a time.
// Requests arrive on the s_ stream (opcode in s_tuser, block and link count
// in s_tdata); each gives exactly one response on the m_ stream (result block
// in m_tdata, status in m_tuser). The data_start register sits on the APB port
// at address 0 and is to be written by the user only while the block is idle;
// the block itself does not enforce this. s_tready is high only while the
// sequencer is idle, so one request is in work at a time. Work per request:
//   alloc / append: examine blocks from data_start up to and including
//                   the free block (append makes a second table write)
//   walk / truncate: follow links; truncate then frees the rest of the chain
//   free chain: visit blocks, the free or last one included
//   out of range or unknown opcode: no table walk, straight to the response
// The table has a single read port, so one entry is read per cycle.
// After reset a clearing pass writes every entry free, one entry per cycle,
// with s_tready low; APB writes are taken meanwhile. A response waits in the
// output register while m_tready is low; the next request is still taken, and
// its response waits until the register is free.
module fat_chain_allocator #(
	parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// requests
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // block [12:0], link_count [25:13]
	input  wire logic [2:0]  s_tuser,   // opcode [2:0]
	// responses
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // result_block [12:0]
	output logic      [0:0]  m_tuser,   // status [0]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [fca_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int EW    = fca_pkg::ENTRY_W;
	localparam int BW    = fca_pkg::BLOCK_W;
	localparam int CW    = fca_pkg::CNT_W;
	localparam logic [EW-1:0] NUM_L = EW'(NUM_BLOCKS);

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_FOLLOW  = 7'b0001000,
		ST_RELEASE = 7'b0010000,
		ST_LINK    = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t             state_q;
	fca_pkg::opcode_t   op_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   blk_q;
	logic               skip_en_q;
	logic [CW-1:0]      remaining_q;
	logic [BW-1:0]      res_q;
	logic               status_q;
	logic [BW-1:0]      data_start_q;
	logic               m_tvalid_q;
	logic [BW-1:0]      m_res_q;
	logic               m_status_q;

	// table port
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [EW-1:0]      ram_rdata;

	// shared unit
	fca_pkg::link_flags_t flags;
	logic [IDX_W-1:0]     next_idx;

	// request fields and derived views
	fca_pkg::opcode_t   op_in;
	logic [BW-1:0]      blk_in;
	logic [CW-1:0]      cnt_in;
	logic [EW-1:0]      blk_ext;
	logic [EW-1:0]      ds_ext;
	logic [EW-1:0]      cur_ext;
	logic [IDX_W-1:0]   entry_idx;
	logic               blk_oor;
	logic               ds_oor;
	logic               s_xfer;
	logic               out_free;

	assign op_in     = fca_pkg::opcode_t'(s_tuser);
	assign blk_in    = s_tdata[BW-1:0];
	assign cnt_in    = s_tdata[BW+CW-1:BW];
	assign blk_ext   = EW'(blk_in);
	assign ds_ext    = EW'(data_start_q);
	assign cur_ext   = EW'(cur_q);
	assign entry_idx = ram_rdata[IDX_W-1:0];
	assign blk_oor   = (blk_ext >= NUM_L);
	assign ds_oor    = (ds_ext >= NUM_L);
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	fca_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fca_link_unit #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_link (
		.cur   (cur_q),
		.entry (ram_rdata),
		.skip  (blk_q),
		.flags (flags),
		.next  (next_idx)
	);

	// table read address and write port
	always_comb begin
		ram_raddr = cur_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = fca_pkg::FAT_FREE;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (op_in == fca_pkg::OP_ALLOC || op_in == fca_pkg::OP_APPEND) begin
					ram_raddr = ds_ext[IDX_W-1:0];
				end else begin
					ram_raddr = blk_ext[IDX_W-1:0];
				end
			end
			ST_SCAN: begin
				ram_raddr = next_idx;
				if (flags.entry_free && !(skip_en_q && flags.skip_hit)) begin
					ram_we    = 1'b1;
					ram_wdata = cur_ext;
				end
			end
			ST_FOLLOW: begin
				ram_raddr = entry_idx;
				if ((remaining_q == '0 || flags.link_ends) && op_q == fca_pkg::OP_TRUNCATE
						&& !flags.entry_free) begin
					ram_we    = 1'b1;
					ram_wdata = cur_ext;
				end
			end
			ST_RELEASE: begin
				ram_raddr = entry_idx;
				ram_we    = !flags.entry_free;
			end
			ST_LINK: begin
				ram_we    = 1'b1;
				ram_waddr = blk_q;
				ram_wdata = cur_ext;
			end
			default: begin
			end
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			op_q        <= fca_pkg::OP_ALLOC;
			blk_q       <= '0;
			skip_en_q   <= 1'b0;
			remaining_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (flags.at_last) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q <= next_idx;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						op_q     <= op_in;
						blk_q    <= blk_ext[IDX_W-1:0];
						res_q    <= '0;
						status_q <= 1'b0;
						case (op_in)
							fca_pkg::OP_ALLOC, fca_pkg::OP_APPEND: begin
								skip_en_q <= (op_in == fca_pkg::OP_APPEND);
								cur_q     <= ds_ext[IDX_W-1:0];
								if (ds_oor || (op_in == fca_pkg::OP_APPEND && blk_oor)) begin
									status_q <= 1'b1;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							fca_pkg::OP_WALK, fca_pkg::OP_TRUNCATE: begin
								cur_q       <= blk_ext[IDX_W-1:0];
								remaining_q <= cnt_in;
								res_q       <= blk_in;
								state_q     <= blk_oor ? ST_DONE : ST_FOLLOW;
							end
							fca_pkg::OP_FREE: begin
								cur_q   <= blk_ext[IDX_W-1:0];
								state_q <= blk_oor ? ST_DONE : ST_RELEASE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (flags.entry_free && !(skip_en_q && flags.skip_hit)) begin
						res_q   <= cur_ext[BW-1:0];
						state_q <= (op_q == fca_pkg::OP_APPEND) ? ST_LINK : ST_DONE;
					end else if (flags.at_last) begin
						status_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						cur_q <= next_idx;
					end
				end
				ST_FOLLOW: begin
					if (remaining_q == '0 || flags.link_ends) begin
						res_q <= cur_ext[BW-1:0];
						if (op_q == fca_pkg::OP_TRUNCATE && !flags.link_ends) begin
							// cut here and free the rest of the chain
							cur_q   <= entry_idx;
							state_q <= ST_RELEASE;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						cur_q       <= entry_idx;
						remaining_q <= remaining_q - CW'(1);
					end
				end
				ST_RELEASE: begin
					if (flags.link_ends) begin
						state_q <= ST_DONE;
					end else begin
						cur_q <= entry_idx;
					end
				end
				ST_LINK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
			m_res_q    <= res_q;
			m_status_q <= status_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(m_res_q);
	assign m_tuser  = m_status_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= fca_pkg::DATA_START_RST;
		end else if (psel && penable && pwrite && pready && paddr == fca_pkg::ADDR_DATA_START) begin
			data_start_q <= pwdata[BW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == fca_pkg::ADDR_DATA_START) ? 32'(data_start_q) : 32'd0;

	// checks on the sequencer
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_tready)
		else $error("request taken while a request is in work");

	a_no_resp_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !m_tvalid_q)
		else $error("response during clearing pass");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> m_tvalid_q)
		else $error("finished response not loaded");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
		else $error("table write outside a request");

endmodule

`default_nettype wire
